### design/sfem_pkg.sv
// Package: widths, reset values, register indexes and control types of the fade mixer.
package sfem_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FADE_W     = 24;
    localparam int SONG_W     = 32;
    localparam int VOL_W      = 16;
    localparam int VOL_FRAC   = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int REM_W      = FADE_W + 1;
    localparam int DIV_CNT_W  = $clog2(GAIN_FRAC + 1);
    localparam int BG_PROD_W  = SAMPLE_W + VOL_W;
    localparam int BG_SHR_W   = BG_PROD_W - VOL_FRAC;

    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(308700);
    localparam logic [SONG_W-1:0] SONG_RESET = SONG_W'(1);
    localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(256);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_LENGTH       = 2'd0,
        REG_SONG_FRAMES       = 2'd1,
        REG_BACKGROUND_ENABLE = 2'd2,
        REG_BACKGROUND_VOLUME = 2'd3
    } sfem_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DIVIDE,
        ST_SQUARE,
        ST_SCALE,
        ST_LOAD
    } sfem_state_t;

    typedef struct packed {
        logic load;
        logic select;
        logic div_step;
        logic square;
        logic scale;
        logic out_load;
    } sfem_cmd_t;

    typedef struct packed {
        logic div_last;
    } sfem_status_t;

endpackage

### design/sfem_if.sv
// Interfaces: input frame channel and output frame channel.
interface sfem_in_if
    import sfem_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       song_start;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic signed [SAMPLE_W-1:0] bg_left_in;
    logic signed [SAMPLE_W-1:0] bg_right_in;

    modport source (output valid, song_start, left_in, right_in, bg_left_in, bg_right_in,
                    input ready);
    modport sink (input valid, song_start, left_in, right_in, bg_left_in, bg_right_in,
                  output ready);
endinterface

interface sfem_out_if
    import sfem_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

### design/sfem_ctrl.sv
// Controller: sequences select, divide, square, scale and output load for one item.
module sfem_ctrl
    import sfem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  sfem_status_t status,
    output sfem_cmd_t    cmd
);

    sfem_state_t state_reg;
    sfem_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SELECT;
            end
            ST_SELECT: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SELECT: cmd.select   = 1'b1;
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_SQUARE: cmd.square   = 1'b1;
            ST_SCALE:  cmd.scale    = 1'b1;
            ST_LOAD:   cmd.out_load = !out_valid_reg || out_ready;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

### design/sfem_dp.sv
// Datapath: config registers, position counter, gain divider, multipliers and output register.
module sfem_dp
    import sfem_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  sfem_cmd_t                  cmd,
    output sfem_status_t               status,
    input  logic                       song_start,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic signed [SAMPLE_W-1:0] bg_left_in,
    input  logic signed [SAMPLE_W-1:0] bg_right_in,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out
);

    logic [FADE_W-1:0]  fade_reg;
    logic [SONG_W-1:0]  song_reg;
    logic               bg_en_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [SONG_W-1:0]  position_reg;
    logic [SONG_W-1:0]  position_next;
    logic [SONG_W-1:0]  pos_reg;

    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [SAMPLE_W-1:0] bg_left_reg;
    logic signed [SAMPLE_W-1:0] bg_right_reg;

    logic                 unity_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [GAIN_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [GAIN_W-1:0]    gain_reg;

    logic signed [SAMPLE_W:0]   faded_l_reg;
    logic signed [SAMPLE_W:0]   faded_r_reg;
    logic signed [SAMPLE_W-1:0] bg_l_reg;
    logic signed [SAMPLE_W-1:0] bg_r_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg;
    logic signed [SAMPLE_W-1:0] right_out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_reg  <= FADE_RESET;
            song_reg  <= SONG_RESET;
            bg_en_reg <= 1'b0;
            vol_reg   <= VOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sfem_reg_t'(cfg_index))
                REG_FADE_LENGTH:       fade_reg  <= cfg_data[FADE_W-1:0];
                REG_SONG_FRAMES:       song_reg  <= cfg_data[SONG_W-1:0];
                REG_BACKGROUND_ENABLE: bg_en_reg <= cfg_data[0];
                REG_BACKGROUND_VOLUME: vol_reg   <= cfg_data[VOL_W-1:0];
                default:               fade_reg  <= fade_reg;
            endcase
        end
    end

    // position counter, saturating
    logic [SONG_W-1:0] pos_eff;
    assign pos_eff = song_start ? '0 : position_reg;

    always_comb
    begin
        position_next = position_reg;
        if (cmd.load)
            position_next = (&pos_eff) ? pos_eff : pos_eff + SONG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_reg <= '0;
        else
            position_reg <= position_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg      <= pos_eff;
            left_reg     <= left_in;
            right_reg    <= right_in;
            bg_left_reg  <= bg_left_in;
            bg_right_reg <= bg_right_in;
        end
    end

    // fade selection
    logic [SONG_W-1:0] fade_ext;
    logic [SONG_W-1:0] remaining;
    logic              pos_in_fade;
    logic              rem_in_fade;
    logic [FADE_W-1:0] fade_n;

    assign fade_ext    = {{(SONG_W-FADE_W){1'b0}}, fade_reg};
    assign remaining   = (pos_reg < song_reg) ? song_reg - pos_reg : '0;
    assign pos_in_fade = pos_reg <= fade_ext;
    assign rem_in_fade = remaining <= fade_ext;
    assign fade_n      = pos_in_fade ? pos_reg[FADE_W-1:0] : remaining[FADE_W-1:0];

    // restoring divider: quotient = n * 2^GAIN_FRAC / fade, one bit per cycle
    logic [REM_W-1:0]  fade_rem;
    logic              div_ge;
    logic [REM_W-1:0]  div_diff;

    assign fade_rem = {1'b0, fade_reg};
    assign div_ge   = rem_reg >= fade_rem;
    assign div_diff = div_ge ? rem_reg - fade_rem : rem_reg;
    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            unity_reg <= (fade_reg == '0) || (!pos_in_fade && !rem_in_fade);
            rem_reg   <= {1'b0, fade_n};
            quot_reg  <= '0;
            cnt_reg   <= DIV_CNT_W'(GAIN_FRAC);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= {div_diff[FADE_W-1:0], 1'b0};
            quot_reg <= {quot_reg[GAIN_W-2:0], div_ge};
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    // gain = quotient^2 >> GAIN_FRAC, or unity when the fade length is zero or outside both fades
    logic [2*GAIN_W-1:0] quot_sq;
    assign quot_sq = {{GAIN_W{1'b0}}, quot_reg} * {{GAIN_W{1'b0}}, quot_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.square)
            gain_reg <= unity_reg ? (GAIN_W'(1) << GAIN_FRAC) : quot_sq[GAIN_FRAC +: GAIN_W];
    end

    // scaling, truncated toward zero; the background result saturates
    function automatic logic [SAMPLE_W-1:0] mag_of(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] m;
        m = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
        return m;
    endfunction

    function automatic logic signed [SAMPLE_W:0] fade_scale(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [GAIN_W-1:0]          g
    );
        logic [SAMPLE_W+GAIN_W-1:0] p;
        logic signed [SAMPLE_W:0]   m;
        p = {{GAIN_W{1'b0}}, mag_of(s)} * {{SAMPLE_W{1'b0}}, g};
        m = $signed({1'b0, p[GAIN_FRAC +: SAMPLE_W]});
        return s[SAMPLE_W-1] ? -m : m;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] bg_scale(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [VOL_W-1:0]           v
    );
        logic [BG_PROD_W-1:0]      p;
        logic [BG_SHR_W-1:0]       m;
        logic signed [SAMPLE_W-1:0] r;
        p = {{VOL_W{1'b0}}, mag_of(s)} * {{SAMPLE_W{1'b0}}, v};
        m = p[VOL_FRAC +: BG_SHR_W];
        if (s[SAMPLE_W-1])
            r = (m > BG_SHR_W'(SAMPLE_MAX) + BG_SHR_W'(1)) ? SAMPLE_MIN : SAMPLE_W'(-m);
        else
            r = (m > BG_SHR_W'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(m);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            faded_l_reg <= fade_scale(left_reg, gain_reg);
            faded_r_reg <= fade_scale(right_reg, gain_reg);
            bg_l_reg    <= bg_en_reg ? bg_scale(bg_left_reg, vol_reg) : '0;
            bg_r_reg    <= bg_en_reg ? bg_scale(bg_right_reg, vol_reg) : '0;
        end
    end

    // mix and saturate into the output register
    function automatic logic signed [SAMPLE_W-1:0] mix_sat(
        input logic signed [SAMPLE_W:0]   a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W+1:0] sum;
        logic signed [SAMPLE_W-1:0] r;
        sum = {a[SAMPLE_W], a} + {{2{b[SAMPLE_W-1]}}, b};
        if (sum > $signed({{2{1'b0}}, SAMPLE_MAX}))
            r = SAMPLE_MAX;
        else if (sum < $signed({{2{1'b1}}, SAMPLE_MIN}))
            r = SAMPLE_MIN;
        else
            r = sum[SAMPLE_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_out_reg  <= mix_sat(faded_l_reg, bg_l_reg);
            right_out_reg <= mix_sat(faded_r_reg, bg_r_reg);
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

### design/stereo_fade_envelope_mixer.sv
// Top level: quadratic fade-in/fade-out stereo mixer with background mix.
// An accepted item passes the select, divide, square, scale and load states before output valid.
// One item at a time: a new item is accepted only after the last is loaded; the gain divider takes 17 steps.
// The next item is accepted while a finished result waits in the output register.
// Reset (rst_n, async low): position 0, registers to defaults, no result pending.
module stereo_fade_envelope_mixer
    import sfem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfem_in_if.sink               frame,
    sfem_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sfem_cmd_t    cmd;
    sfem_status_t status;

    sfem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfem_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .song_start  (frame.song_start),
        .left_in     (frame.left_in),
        .right_in    (frame.right_in),
        .bg_left_in  (frame.bg_left_in),
        .bg_right_in (frame.bg_right_in),
        .left_out    (result.left_out),
        .right_out   (result.right_out)
    );

endmodule
